// ----- rtl/tre_pkg.sv -----
// ----------------------------------------------------------------------------
// tre_pkg
// Shared widths, codes and divider request/response types for the transfer
// rate and ETA estimator.
// ----------------------------------------------------------------------------
package tre_pkg;

    // Sliding window depth (number of held deltas)
    localparam int WINDOW = 100;

    localparam int DATA_W  = 32;
    localparam int BYTES_W = 31;
    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W  = FILL_W + 1;
    localparam int SUM_W   = DATA_W + FILL_W;
    localparam int CNT_W   = $clog2(SUM_W);

    // Item opcodes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic                     start;
        logic signed [SUM_W-1:0]  dividend;
        logic signed [DATA_W-1:0] divisor;
    } tre_div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [SUM_W-1:0]  quotient;
    } tre_div_rsp_t;

endpackage

// ----- rtl/tre_ram.sv -----
// ----------------------------------------------------------------------------
// tre_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module tre_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tre_divider.sv -----
// ----------------------------------------------------------------------------
// tre_divider
// Serial signed divider, restoring, one quotient bit per cycle. Quotient is
// truncated toward zero. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module tre_divider
    import tre_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  tre_div_req_t req,
    output tre_div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dsr_reg;
    logic [SUM_W-1:0]  quo_reg;

    logic [DATA_W:0]   trial;
    logic              fits;

    // one restoring step
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W - 1);
                rem_reg  <= '0;
                neg_reg  <= req.dividend[SUM_W-1] ^ req.divisor[DATA_W-1];
                quo_reg  <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend)
                                                  : req.dividend;
                dsr_reg  <= req.divisor[DATA_W-1] ? DATA_W'(-req.divisor)
                                                  : req.divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? DATA_W'(trial - {1'b0, dsr_reg}) : trial[DATA_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? SUM_W'(-quo_reg) : quo_reg;

endmodule

// ----- rtl/transfer_rate_and_eta_estimator.sv -----
// ----------------------------------------------------------------------------
// transfer_rate_and_eta_estimator
// Sliding-window moving average of per-tick byte deltas, giving transfer
// speed and an estimate of ticks remaining.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                                   | handshake
//  --------+-----------+-------------------------------------------+---------------
//  s_      | in        | op, active, current_bytes, total_bytes    | s_valid/s_ready
//  m_      | out       | speed, time_remaining                     | m_valid/m_ready
//
//  One transaction in, one transaction out, one item in flight at a time.
//  Restart or inactive tick: from accept straight to S_OUT, which loads the
//  result register. Active tick: S_EVICT (only when the window is full and the
//  oldest delta is evicted), S_ADD, then S_DIV1/S_WAIT1 and S_DIV2/S_WAIT2 on
//  the shared serial divider, one quotient each, then S_OUT. A zero speed skips
//  the second division.
//  A finished result sits in the output register; the next transaction is
//  accepted while it waits, and the block stalls only before overwriting it.
//  Reset is synchronous, active low; the delta memory needs no clearing pass.
//
module transfer_rate_and_eta_estimator
    import tre_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_op,
    input  logic                     s_active,
    input  logic [BYTES_W-1:0]       s_current_bytes,
    input  logic [BYTES_W-1:0]       s_total_bytes,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_speed,
    output logic signed [DATA_W-1:0] m_time_remaining
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,   // oldest delta read back, subtract from sum, overwrite
        S_ADD,     // add new delta to sum
        S_DIV1,    // launch sum / fill
        S_WAIT1,
        S_DIV2,    // launch (total - current) / speed
        S_WAIT2,
        S_OUT      // load result register
    } state_t;

    state_t                    state_reg, state_next;
    logic [FILL_W-1:0]         fill_reg, fill_next;
    logic [IDX_W-1:0]          oldest_reg, oldest_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [BYTES_W-1:0]        prev_reg, prev_next;
    logic signed [DATA_W-1:0]  speed_reg, speed_next;
    logic signed [DATA_W-1:0]  remain_reg, remain_next;
    logic [BYTES_W-1:0]        cur_reg, cur_next;
    logic [BYTES_W-1:0]        total_reg, total_next;
    logic signed [DATA_W-1:0]  delta_reg, delta_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0]  m_speed_reg, m_speed_next;
    logic signed [DATA_W-1:0]  m_remain_reg, m_remain_next;

    // delta memory port
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [DATA_W-1:0]         ram_wdata;
    logic [DATA_W-1:0]         ram_rdata;

    tre_div_req_t              div_req;
    tre_div_rsp_t              div_rsp;

    logic signed [DATA_W-1:0]  delta_now;
    logic signed [DATA_W-1:0]  left_bytes;
    logic [SLOT_W-1:0]         slot_sum;
    logic [IDX_W-1:0]          slot_free;

    // new delta against the previous count; always fits 32 bits signed
    assign delta_now  = $signed({1'b0, s_current_bytes}) - $signed({1'b0, prev_reg});
    assign left_bytes = $signed({1'b0, total_reg}) - $signed({1'b0, cur_reg});

    // first free slot: oldest + fill, wrapped once
    assign slot_sum  = SLOT_W'(oldest_reg) + SLOT_W'(fill_reg);
    assign slot_free = (slot_sum >= SLOT_W'(WINDOW)) ? IDX_W'(slot_sum - SLOT_W'(WINDOW))
                                                     : slot_sum[IDX_W-1:0];

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        oldest_next   = oldest_reg;
        sum_next      = sum_reg;
        prev_next     = prev_reg;
        speed_next    = speed_reg;
        remain_next   = remain_reg;
        cur_next      = cur_reg;
        total_next    = total_reg;
        delta_next    = delta_reg;
        m_valid_next  = m_valid_reg;
        m_speed_next  = m_speed_reg;
        m_remain_next = m_remain_reg;

        ram_we        = 1'b0;
        ram_waddr     = slot_free;
        ram_wdata     = delta_now;

        div_req.start    = 1'b0;
        div_req.dividend = sum_reg;
        div_req.divisor  = DATA_W'(fill_reg);

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cur_next   = s_current_bytes;
                    total_next = s_total_bytes;
                    if (s_op == OP_RESTART) begin
                        // window is kept, only the rate outputs clear
                        prev_next   = s_current_bytes;
                        speed_next  = '0;
                        remain_next = '0;
                        state_next  = S_OUT;
                    end else if (s_active) begin
                        delta_next = delta_now;
                        prev_next  = s_current_bytes;
                        if (fill_reg == FILL_W'(WINDOW)) begin
                            // read of oldest_reg is in flight this cycle
                            state_next = S_EVICT;
                        end else begin
                            ram_we     = 1'b1;
                            fill_next  = fill_reg + 1'b1;
                            state_next = S_ADD;
                        end
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_EVICT: begin
                ram_we      = 1'b1;
                ram_waddr   = oldest_reg;
                ram_wdata   = delta_reg;
                sum_next    = sum_reg - SUM_W'($signed(ram_rdata));
                oldest_next = (oldest_reg == IDX_W'(WINDOW - 1)) ? '0 : oldest_reg + 1'b1;
                state_next  = S_ADD;
            end
            S_ADD: begin
                sum_next   = sum_reg + SUM_W'(delta_reg);
                state_next = S_DIV1;
            end
            S_DIV1: begin
                div_req.start = 1'b1;
                state_next    = S_WAIT1;
            end
            S_WAIT1: begin
                if (div_rsp.done) begin
                    speed_next = div_rsp.quotient[DATA_W-1:0];
                    // zero speed keeps the old estimate
                    state_next = (div_rsp.quotient[DATA_W-1:0] != '0) ? S_DIV2 : S_OUT;
                end
            end
            S_DIV2: begin
                div_req.start    = 1'b1;
                div_req.dividend = SUM_W'(left_bytes);
                div_req.divisor  = speed_reg;
                state_next       = S_WAIT2;
            end
            S_WAIT2: begin
                if (div_rsp.done) begin
                    remain_next = div_rsp.quotient[DATA_W-1:0];
                    state_next  = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_speed_next  = speed_reg;
                    m_remain_next = remain_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            oldest_reg  <= '0;
            sum_reg     <= '0;
            prev_reg    <= '0;
            speed_reg   <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            oldest_reg  <= oldest_next;
            sum_reg     <= sum_next;
            prev_reg    <= prev_next;
            speed_reg   <= speed_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        total_reg    <= total_next;
        delta_reg    <= delta_next;
        m_speed_reg  <= m_speed_next;
        m_remain_reg <= m_remain_next;
    end

    // window of deltas; read port always points at the oldest entry
    tre_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (oldest_reg),
        .rdata (ram_rdata)
    );

    tre_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_valid          = m_valid_reg;
    assign m_speed          = m_speed_reg;
    assign m_time_remaining = m_remain_reg;

endmodule

// ----- rtl/tre_checker.sv -----
// ----------------------------------------------------------------------------
// tre_checker
// Port-level checks on the estimator's handshakes and sequencing.
// ----------------------------------------------------------------------------
module tre_checker
    import tre_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_speed,
    input logic [DATA_W-1:0] m_time_remaining
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_speed) && $stable(m_time_remaining))
        else $error("result changed while stalled");

    // one transaction in flight: busy right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted while busy");

    // a new result is only produced while the input side is busy
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without work");

    // no result straight out of reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind transfer_rate_and_eta_estimator tre_checker u_tre_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_speed          (m_speed),
    .m_time_remaining (m_time_remaining)
);
